### sv/first_fit_heap_allocator_top_defines.svh
// Assertion macros for the heap allocator
`ifndef FIRST_FIT_HEAP_ALLOCATOR_TOP_DEFINES_SVH
`define FIRST_FIT_HEAP_ALLOCATOR_TOP_DEFINES_SVH
// Check that a condition implies a result in the same cycle
`define FFH_ASSERT_IMP(lbl, clk, rstn, cond, res) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (cond) |-> (res)) \
        else $error("assertion failed");
// Check that a condition implies a result in the next cycle
`define FFH_ASSERT_NXT(lbl, clk, rstn, cond, res) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (cond) |=> (res)) \
        else $error("assertion failed");
`endif

### sv/ffha_pkg.sv
// Shared constants and status codes for the heap allocator
package ffha_pkg;
    localparam int unsigned HEAP_BYTES_DEF   = 1048576;
    localparam int unsigned HEADER_BYTES_DEF = 12;
    localparam int unsigned MAX_BLOCKS_DEF   = 64;
    localparam int unsigned SIZE_W           = 20;
    localparam int unsigned STATUS_W         = 3;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 3'd0,
        ST_ZERO    = 3'd1,
        ST_NOMEM   = 3'd2,
        ST_UNKNOWN = 3'd3,
        ST_FULL    = 3'd4
    } status_t;

    typedef enum logic {
        REQ_ALLOC = 1'b0,
        REQ_FREE  = 1'b1
    } req_type_t;
endpackage

### sv/first_fit_heap_allocator_top.sv
// Top level of the first-fit heap allocator with block coalescing
// Flow: a zero-size request goes straight to the output; allocate walks the table entry
// by entry and shifts later entries up on a split; free walks the table to find the
// block, then sweeps it to merge free runs, with one extra write per run.
// Throughput: one request at a time; ready again once the result has been taken.
// Reset: aresetn synchronous active low empties the table and the break.
module first_fit_heap_allocator_top #(
    parameter int unsigned HEAP_BYTES   = ffha_pkg::HEAP_BYTES_DEF,
    parameter int unsigned HEADER_BYTES = ffha_pkg::HEADER_BYTES_DEF,
    parameter int unsigned MAX_BLOCKS   = ffha_pkg::MAX_BLOCKS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // req_size[19:0], block_offset[39:20]
    input  logic        s_tuser,   // req_type
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata    // status[2:0], result_offset[22:3], zero pad
);
    import ffha_pkg::*;
    `include "first_fit_heap_allocator_top_defines.svh"

    localparam int unsigned IW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int unsigned CW = $clog2(MAX_BLOCKS + 1);
    localparam int unsigned AW = SIZE_W + 2;
    localparam logic [AW-1:0] HDR  = AW'(HEADER_BYTES);
    localparam logic [AW-1:0] HEAP = AW'(HEAP_BYTES);
    localparam logic [CW-1:0] MAXC = CW'(MAX_BLOCKS);

    typedef enum logic [4:0] {
        S_IDLE, S_ARD, S_AWT, S_ACHK, S_SHRD, S_SHWT, S_SHWR, S_SPLIT, S_APP,
        S_FRD, S_FWT, S_FCHK, S_MRD, S_MWT, S_MCHK, S_MCPY, S_OUT
    } state_t;

    logic [SIZE_W-1:0] mem_size [MAX_BLOCKS];
    logic              mem_used [MAX_BLOCKS];
    logic [SIZE_W-1:0] rd_size_reg;
    logic              rd_used_reg;
    logic [IW-1:0]     rd_addr;
    logic              wr_en;
    logic [IW-1:0]     wr_addr;
    logic [SIZE_W-1:0] wr_size;
    logic              wr_used;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_size[wr_addr] <= wr_size;
            mem_used[wr_addr] <= wr_used;
        end
        rd_size_reg <= mem_size[rd_addr];
        rd_used_reg <= mem_used[rd_addr];
    end

    state_t            state_reg, state_next;
    logic [CW-1:0]     count_reg, count_next;
    logic [AW-1:0]     brk_reg, brk_next;
    logic [CW-1:0]     i_reg, i_next;
    logic [CW-1:0]     w_reg, w_next;
    logic [AW-1:0]     addr_reg, addr_next;
    logic [SIZE_W-1:0] size_reg, size_next;
    logic [SIZE_W-1:0] off_reg, off_next;
    logic [SIZE_W-1:0] acc_reg, acc_next;
    logic              accf_reg, accf_next;
    logic [SIZE_W-1:0] hold_reg, hold_next;
    status_t           st_reg, st_next;
    logic [SIZE_W-1:0] res_reg, res_next;
    logic              mv_reg, mv_next;

    logic [AW-1:0] total;
    logic [AW-1:0] sum;
    assign total = AW'(size_reg) + HDR;
    assign sum   = addr_reg + HDR + AW'(rd_size_reg);

    assign s_tready = (state_reg == S_IDLE) && !mv_reg;
    assign m_tvalid = mv_reg;
    assign m_tdata  = {1'b0, res_reg, st_reg};

    always_comb begin
        state_next = state_reg;
        count_next = count_reg;
        brk_next   = brk_reg;
        i_next     = i_reg;
        w_next     = w_reg;
        addr_next  = addr_reg;
        size_next  = size_reg;
        off_next   = off_reg;
        acc_next   = acc_reg;
        accf_next  = accf_reg;
        hold_next  = hold_reg;
        st_next    = st_reg;
        res_next   = res_reg;
        mv_next    = mv_reg;
        rd_addr    = i_reg[IW-1:0];
        wr_en      = 1'b0;
        wr_addr    = i_reg[IW-1:0];
        wr_size    = size_reg;
        wr_used    = 1'b1;
        if (mv_reg && m_tready) begin
            mv_next = 1'b0;
        end
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid && s_tready) begin
                    size_next = s_tdata[19:0];
                    off_next  = s_tdata[39:20];
                    i_next    = '0;
                    w_next    = '0;
                    addr_next = '0;
                    accf_next = 1'b0;
                    res_next  = '0;
                    st_next   = ST_OK;
                    if (s_tuser == REQ_FREE) begin
                        state_next = S_FRD;
                    end else if (s_tdata[19:0] == '0) begin
                        st_next    = ST_ZERO;
                        state_next = S_OUT;
                    end else begin
                        state_next = S_ARD;
                    end
                end
            end
            S_ARD: begin
                state_next = (i_reg < count_reg) ? S_AWT : S_APP;
            end
            S_AWT: state_next = S_ACHK;
            S_ACHK: begin
                if (!rd_used_reg && size_reg == rd_size_reg) begin
                    wr_en      = 1'b1;
                    res_next   = SIZE_W'(addr_reg + HDR);
                    state_next = S_OUT;
                end else if (!rd_used_reg && total <= AW'(rd_size_reg)) begin
                    if (count_reg >= MAXC) begin
                        st_next    = ST_FULL;
                        state_next = S_OUT;
                    end else begin
                        hold_next  = SIZE_W'(AW'(rd_size_reg) - total);
                        res_next   = SIZE_W'(addr_reg + HDR);
                        w_next     = i_reg;
                        i_next     = count_reg - CW'(1);
                        state_next = S_SHRD;
                    end
                end else begin
                    addr_next  = sum;
                    i_next     = i_reg + CW'(1);
                    state_next = S_ARD;
                end
            end
            S_SHRD: begin
                state_next = (i_reg > w_reg) ? S_SHWT : S_SPLIT;
            end
            S_SHWT: state_next = S_SHWR;
            S_SHWR: begin
                wr_en      = 1'b1;
                wr_addr    = IW'(i_reg + CW'(1));
                wr_size    = rd_size_reg;
                wr_used    = rd_used_reg;
                i_next     = i_reg - CW'(1);
                state_next = S_SHRD;
            end
            S_SPLIT: begin
                if (!accf_reg) begin
                    wr_en     = 1'b1;
                    wr_addr   = w_reg[IW-1:0];
                    accf_next = 1'b1;
                end else begin
                    wr_en      = 1'b1;
                    wr_addr    = IW'(w_reg + CW'(1));
                    wr_size    = hold_reg;
                    wr_used    = 1'b0;
                    count_next = count_reg + CW'(1);
                    state_next = S_OUT;
                end
            end
            S_APP: begin
                if (count_reg >= MAXC) begin
                    st_next = ST_FULL;
                end else if (brk_reg + total >= HEAP) begin
                    st_next = ST_NOMEM;
                end else begin
                    wr_en      = 1'b1;
                    wr_addr    = count_reg[IW-1:0];
                    count_next = count_reg + CW'(1);
                    res_next   = SIZE_W'(brk_reg + HDR);
                    brk_next   = brk_reg + total;
                end
                state_next = S_OUT;
            end
            S_FRD: begin
                if (i_reg < count_reg) begin
                    state_next = S_FWT;
                end else begin
                    st_next    = ST_UNKNOWN;
                    state_next = S_OUT;
                end
            end
            S_FWT: state_next = S_FCHK;
            S_FCHK: begin
                if (addr_reg + HDR == AW'(off_reg)) begin
                    wr_en      = 1'b1;
                    wr_size    = rd_size_reg;
                    wr_used    = 1'b0;
                    i_next     = '0;
                    state_next = S_MRD;
                end else begin
                    addr_next  = sum;
                    i_next     = i_reg + CW'(1);
                    state_next = S_FRD;
                end
            end
            S_MRD: begin
                if (i_reg < count_reg) begin
                    state_next = S_MWT;
                end else begin
                    if (accf_reg) begin
                        wr_en   = 1'b1;
                        wr_addr = w_reg[IW-1:0];
                        wr_size = acc_reg;
                        wr_used = 1'b0;
                        count_next = w_reg + CW'(1);
                    end else begin
                        count_next = w_reg;
                    end
                    state_next = S_OUT;
                end
            end
            S_MWT: state_next = S_MCHK;
            S_MCHK: begin
                i_next     = i_reg + CW'(1);
                state_next = S_MRD;
                if (!rd_used_reg) begin
                    if (accf_reg) begin
                        acc_next = SIZE_W'(AW'(acc_reg) + HDR + AW'(rd_size_reg));
                    end else begin
                        acc_next  = rd_size_reg;
                        accf_next = 1'b1;
                    end
                end else begin
                    if (accf_reg) begin
                        wr_en   = 1'b1;
                        wr_addr = w_reg[IW-1:0];
                        wr_size = acc_reg;
                        wr_used = 1'b0;
                        hold_next  = rd_size_reg;
                        w_next     = w_reg + CW'(1);
                        accf_next  = 1'b0;
                        state_next = S_MCPY;
                    end else begin
                        wr_en   = 1'b1;
                        wr_addr = w_reg[IW-1:0];
                        wr_size = rd_size_reg;
                        wr_used = 1'b1;
                        w_next  = w_reg + CW'(1);
                    end
                end
            end
            S_MCPY: begin
                wr_en      = 1'b1;
                wr_addr    = w_reg[IW-1:0];
                wr_size    = hold_reg;
                wr_used    = 1'b1;
                w_next     = w_reg + CW'(1);
                state_next = S_MRD;
            end
            S_OUT: begin
                if (!mv_reg || m_tready) begin
                    mv_next    = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            brk_reg   <= '0;
            mv_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            brk_reg   <= brk_next;
            mv_reg    <= mv_next;
        end
        i_reg    <= i_next;
        w_reg    <= w_next;
        addr_reg <= addr_next;
        size_reg <= size_next;
        off_reg  <= off_next;
        acc_reg  <= acc_next;
        accf_reg <= accf_next;
        hold_reg <= hold_next;
        st_reg   <= st_next;
        res_reg  <= res_next;
    end

    `FFH_ASSERT_IMP(a_ready_idle, aclk, aresetn, s_tready, state_reg == S_IDLE)
    `FFH_ASSERT_IMP(a_count_max, aclk, aresetn, 1'b1, count_reg <= MAXC)
    `FFH_ASSERT_NXT(a_out_valid, aclk, aresetn, state_reg == S_OUT && !mv_reg, mv_reg)
endmodule
